// ----- sv/cstat_pkg.sv -----
// ----------------------------------------------------------------------------
// cstat_pkg
// Types and constants shared by the coefficient statistics block.
// ----------------------------------------------------------------------------
package cstat_pkg;

	localparam int COEFF_WIDTH  = 24;
	localparam int COUNT_WIDTH  = 40;
	localparam int NUM_BINS     = COEFF_WIDTH + 1;
	localparam int BIN_WIDTH    = $clog2(NUM_BINS);
	localparam int SUM_WIDTH    = 48;
	localparam int ENERGY_WIDTH = 63;
	localparam int SQ_WIDTH     = 2 * COEFF_WIDTH;

	localparam logic [1:0] OP_ACCUM = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic signed [COEFF_WIDTH-1:0] COEFF_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
	localparam logic signed [COEFF_WIDTH-1:0] COEFF_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
	localparam logic signed [SUM_WIDTH-1:0]   SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0]   SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic [ENERGY_WIDTH-1:0]       ENERGY_TOP = {ENERGY_WIDTH{1'b1}};

	typedef struct packed {
		logic [1:0]                    opcode;
		logic signed [COEFF_WIDTH-1:0] coeff;
		logic [BIN_WIDTH-1:0]          bin_index;
	} cstat_item_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0]        bin_count;
		logic signed [SUM_WIDTH-1:0]   coeff_sum;
		logic signed [COEFF_WIDTH-1:0] coeff_min;
		logic signed [COEFF_WIDTH-1:0] coeff_max;
		logic [ENERGY_WIDTH-1:0]       energy;
		logic [COUNT_WIDTH-1:0]        zero_count;
		logic [COUNT_WIDTH-1:0]        total_count;
	} cstat_result_t;

	// Item after the front stage: the bin it falls in and its square.
	typedef struct packed {
		logic [1:0]                    opcode;
		logic signed [COEFF_WIDTH-1:0] coeff;
		logic [BIN_WIDTH-1:0]          bin_index;
		logic [BIN_WIDTH-1:0]          bin_len;
		logic [SQ_WIDTH-1:0]           square;
	} cstat_prep_t;

endpackage

// ----- sv/cstat_prep.sv -----
// ----------------------------------------------------------------------------
// cstat_prep
// Front stage: squares the coefficient and finds the bit length of its
// magnitude, then holds both in the second pipeline register.
// ----------------------------------------------------------------------------
module cstat_prep import cstat_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  cstat_item_t item_s1,
	output cstat_prep_t prep_s2
);

	function automatic logic [BIN_WIDTH-1:0] bit_len(input logic [COEFF_WIDTH-1:0] mag);
		logic [BIN_WIDTH-1:0] n;
		n = '0;
		for (int i = 0; i < COEFF_WIDTH; i++) begin
			if (mag[i]) begin
				n = BIN_WIDTH'(i + 1);
			end
		end
		return n;
	endfunction

	logic [COEFF_WIDTH-1:0]       mag;
	logic signed [SQ_WIDTH-1:0]   square;

	// The most negative coefficient has a magnitude that still fits unsigned.
	assign mag    = item_s1.coeff[COEFF_WIDTH-1] ? -item_s1.coeff : item_s1.coeff;
	assign square = SQ_WIDTH'(item_s1.coeff) * SQ_WIDTH'(item_s1.coeff);

	always_ff @(posedge clk) begin
		if (load) begin
			prep_s2.opcode    <= item_s1.opcode;
			prep_s2.coeff     <= item_s1.coeff;
			prep_s2.bin_index <= item_s1.bin_index;
			prep_s2.bin_len   <= bit_len(mag);
			prep_s2.square    <= square;
		end
	end

endmodule

// ----- sv/cstat_accum.sv -----
// ----------------------------------------------------------------------------
// cstat_accum
// Statistics state: histogram, saturating sums, min, max and counters, with
// the result register that reports the state after each step.
// ----------------------------------------------------------------------------
module cstat_accum import cstat_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  cstat_prep_t   prep_s2,
	output cstat_result_t result_q
);

	logic [COUNT_WIDTH-1:0]        bins_q [NUM_BINS];
	logic signed [SUM_WIDTH-1:0]   sum_q;
	logic signed [COEFF_WIDTH-1:0] min_q;
	logic signed [COEFF_WIDTH-1:0] max_q;
	logic [ENERGY_WIDTH-1:0]       energy_q;
	logic [COUNT_WIDTH-1:0]        zeros_q;
	logic [COUNT_WIDTH-1:0]        items_q;

	logic [BIN_WIDTH-1:0]          bin_sel;
	logic [COUNT_WIDTH-1:0]        bin_cur;
	logic [COUNT_WIDTH-1:0]        bin_new;
	logic [SUM_WIDTH:0]            sum_ext;
	logic [ENERGY_WIDTH:0]         energy_ext;
	logic                          is_zero;
	cstat_result_t                 next;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + COUNT_WIDTH'(1);
	endfunction

	always_comb begin
		bin_sel    = (prep_s2.opcode == OP_READ) ? prep_s2.bin_index : prep_s2.bin_len;
		bin_cur    = (32'(bin_sel) < NUM_BINS) ? bins_q[bin_sel] : '0;
		bin_new    = bump(bin_cur);
		sum_ext    = {sum_q[SUM_WIDTH-1], sum_q}
		           + {{(SUM_WIDTH+1-COEFF_WIDTH){prep_s2.coeff[COEFF_WIDTH-1]}}, prep_s2.coeff};
		energy_ext = {1'b0, energy_q} + (ENERGY_WIDTH+1)'(prep_s2.square);
		is_zero    = (prep_s2.coeff == '0);

		next.bin_count   = '0;
		next.coeff_sum   = sum_q;
		next.coeff_min   = min_q;
		next.coeff_max   = max_q;
		next.energy      = energy_q;
		next.zero_count  = zeros_q;
		next.total_count = items_q;

		unique case (prep_s2.opcode)
			OP_ACCUM: begin
				next.bin_count = bin_new;
				if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
					next.coeff_sum = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
				end else begin
					next.coeff_sum = sum_ext[SUM_WIDTH-1:0];
				end
				if (prep_s2.coeff < min_q) begin
					next.coeff_min = prep_s2.coeff;
				end
				if (prep_s2.coeff > max_q) begin
					next.coeff_max = prep_s2.coeff;
				end
				next.energy = energy_ext[ENERGY_WIDTH] ? ENERGY_TOP
				                                       : energy_ext[ENERGY_WIDTH-1:0];
				if (is_zero) begin
					next.zero_count = bump(zeros_q);
				end
				next.total_count = bump(items_q);
			end
			OP_READ: begin
				next.bin_count = bin_cur;
			end
			OP_CLEAR: begin
				next.coeff_sum   = '0;
				next.coeff_min   = COEFF_MAX;
				next.coeff_max   = COEFF_MIN;
				next.energy      = '0;
				next.zero_count  = '0;
				next.total_count = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
			sum_q    <= '0;
			min_q    <= COEFF_MAX;
			max_q    <= COEFF_MIN;
			energy_q <= '0;
			zeros_q  <= '0;
			items_q  <= '0;
		end else if (fire) begin
			if (prep_s2.opcode == OP_CLEAR) begin
				for (int i = 0; i < NUM_BINS; i++) begin
					bins_q[i] <= '0;
				end
			end else if (prep_s2.opcode == OP_ACCUM) begin
				bins_q[bin_sel] <= bin_new;
			end
			sum_q    <= next.coeff_sum;
			min_q    <= next.coeff_min;
			max_q    <= next.coeff_max;
			energy_q <= next.energy;
			zeros_q  <= next.zero_count;
			items_q  <= next.total_count;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= next;
		end
	end

endmodule

// ----- sv/coefficient_statistics.sv -----
// ----------------------------------------------------------------------------
// coefficient_statistics
// Running statistics over a stream of signed transform coefficients.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while item_stall is low and
// returns exactly one result per item. Each item passes the input register,
// then the front stage that squares the coefficient and finds the bit length
// of its magnitude, and then the statistics stage, whose read-modify-write
// of the histogram and the sums sets the rate of one item per cycle. Opcode
// accumulate adds the coefficient to the histogram, the saturating sum and
// energy, the minimum, the maximum and the counters; read reports one
// histogram bin; clear restores every statistic to its reset value. Every
// result reports the statistics after its own step.
// Each pipeline stage moves on as soon as the stage after it has room, so
// items keep flowing in while a finished result waits to be taken, and a
// stall on the result side reaches the input only once every stage is full.
// ----------------------------------------------------------------------------
module coefficient_statistics import cstat_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  cstat_item_t   item,
	output logic          result_valid,
	input  logic          result_stall,
	output cstat_result_t result
);

	// Stage valid flags.
	logic        valid_s1;
	logic        valid_s2;
	logic        result_valid_q;
	cstat_item_t item_s1;
	cstat_prep_t prep_s2;

	// A stage may load when it is empty or when its contents move on in the
	// same cycle.
	logic result_free;
	logic s2_free;
	logic s1_free;
	logic s2_fire;
	logic s1_fire;
	logic item_take;

	assign result_free = !result_valid_q || !result_stall;
	assign s2_fire     = valid_s2 && result_free;
	assign s2_free     = !valid_s2 || result_free;
	assign s1_fire     = valid_s1 && s2_free;
	assign s1_free     = !valid_s1 || s2_free;
	assign item_stall  = !s1_free;
	assign item_take   = item_valid && s1_free;

	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= item_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (result_free) begin
				result_valid_q <= valid_s2;
			end
		end
	end

	// The input register holds the transferred item for the front stage.
	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	cstat_prep u_prep (
		.clk     (clk),
		.load    (s1_fire),
		.item_s1 (item_s1),
		.prep_s2 (prep_s2)
	);

	cstat_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (s2_fire),
		.prep_s2  (prep_s2),
		.result_q (result)
	);

	// Once any coefficient has been counted since the last clear, the minimum
	// can no longer lie above the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.total_count != '0) |-> (result.coeff_min <= result.coeff_max))
		else $error("minimum above maximum after coefficients were counted");

	// Zero coefficients are a subset of all coefficients, and both counters
	// saturate at the same top value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.zero_count <= result.total_count))
		else $error("zero count exceeds total count");

	// No histogram bin can hold more than the number of coefficients seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.bin_count <= result.total_count))
		else $error("bin count exceeds total count");

	// A result stage that could take the front stage's item must end up valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		s2_fire |=> result_valid)
		else $error("front stage item lost on the way to the result register");

endmodule
